// ----- rtl/frp_pkg.sv -----
package frp_pkg;

  // Field widths fixed by the frame format.
  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 9;

  // Framing constants.
  localparam logic [ByteW-1:0] SyncFirst      = 8'hAA;
  localparam logic [ByteW-1:0] SyncSecond     = 8'hBB;
  localparam logic [ByteW-1:0] AddrBroadcastA = 8'hFF;
  localparam logic [ByteW-1:0] AddrBroadcastB = 8'hEE;
  localparam int unsigned      FrameOverhead  = 6;

  // Fixed byte positions at the head of a frame.
  localparam logic [PosW-1:0] PosSync1  = 9'd0;
  localparam logic [PosW-1:0] PosSync2  = 9'd1;
  localparam logic [PosW-1:0] PosSource = 9'd2;
  localparam logic [PosW-1:0] PosDest   = 9'd3;
  localparam logic [PosW-1:0] PosLength = 9'd4;

  // Per-byte outcome code.
  typedef enum logic [2:0] {
    OUT_IGNORED  = 3'd0,
    OUT_ACCEPTED = 3'd1,
    OUT_DROPPED  = 3'd2,
    OUT_GOOD     = 3'd3,
    OUT_BAD      = 3'd4
  } outcome_e;

  // One result item.
  typedef struct packed {
    outcome_e              outcome;
    logic [PosW-1:0]       byte_index;
    logic [ByteW-1:0]      byte_value;
  } result_t;

endpackage

// ----- rtl/frp_deframe.sv -----
module frp_deframe #(
  parameter int unsigned FRAME_BUFFER_BYTES = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       take_i,
  input  logic [frp_pkg::ByteW-1:0]  rx_byte_i,
  input  logic [frp_pkg::ByteW-1:0]  local_address_i,
  output frp_pkg::result_t           result_o
);

  localparam int unsigned CmpW = frp_pkg::ByteW + 2;
  localparam logic [CmpW-1:0] MaxFrame = CmpW'(FRAME_BUFFER_BYTES);
  localparam logic [CmpW-1:0] Overhead = CmpW'(frp_pkg::FrameOverhead);

  logic [frp_pkg::PosW-1:0]  pos_q, pos_d;
  logic [frp_pkg::ByteW-1:0] len_q, len_d;
  logic [frp_pkg::ByteW-1:0] xor_q, xor_d;

  logic [frp_pkg::PosW-1:0]  last_payload_pos;
  logic [frp_pkg::PosW-1:0]  check_pos;
  logic                      dest_ok;
  logic                      len_too_big;
  frp_pkg::outcome_e         outcome;

  assign last_payload_pos = {1'b0, len_q} + frp_pkg::PosW'(4);
  assign check_pos        = {1'b0, len_q} + frp_pkg::PosW'(5);
  assign dest_ok     = (rx_byte_i == local_address_i) ||
                       (rx_byte_i == frp_pkg::AddrBroadcastA) ||
                       (rx_byte_i == frp_pkg::AddrBroadcastB);
  assign len_too_big = ({2'b00, rx_byte_i} + Overhead) > MaxFrame;

  // Decide the outcome of this byte and the next frame state.
  always_comb begin
    outcome = frp_pkg::OUT_ACCEPTED;
    pos_d   = pos_q;
    len_d   = len_q;
    xor_d   = xor_q;
    if (pos_q == frp_pkg::PosSync1) begin
      if (rx_byte_i == frp_pkg::SyncFirst) begin
        xor_d = '0;
        pos_d = frp_pkg::PosSync2;
      end else begin
        outcome = frp_pkg::OUT_IGNORED;
      end
    end else if (pos_q == frp_pkg::PosSync2) begin
      if (rx_byte_i == frp_pkg::SyncSecond) begin
        pos_d = frp_pkg::PosSource;
      end else begin
        outcome = frp_pkg::OUT_DROPPED;
      end
    end else if (pos_q == frp_pkg::PosSource) begin
      xor_d = rx_byte_i;
      pos_d = frp_pkg::PosDest;
    end else if (pos_q == frp_pkg::PosDest) begin
      if (dest_ok) begin
        xor_d = xor_q ^ rx_byte_i;
        pos_d = frp_pkg::PosLength;
      end else begin
        outcome = frp_pkg::OUT_DROPPED;
      end
    end else if (pos_q == frp_pkg::PosLength) begin
      if (len_too_big) begin
        outcome = frp_pkg::OUT_DROPPED;
      end else begin
        len_d = rx_byte_i;
        xor_d = xor_q ^ rx_byte_i;
        pos_d = pos_q + frp_pkg::PosW'(1);
      end
    end else if (pos_q <= last_payload_pos) begin
      xor_d = xor_q ^ rx_byte_i;
      pos_d = pos_q + frp_pkg::PosW'(1);
    end else if (pos_q == check_pos) begin
      outcome = (xor_q == rx_byte_i) ? frp_pkg::OUT_GOOD : frp_pkg::OUT_BAD;
    end else begin
      // Position past the check byte cannot be reached; recover anyway.
      outcome = frp_pkg::OUT_DROPPED;
    end

    // Every end of frame, good or not, returns to hunting.
    if (outcome == frp_pkg::OUT_DROPPED || outcome == frp_pkg::OUT_GOOD ||
        outcome == frp_pkg::OUT_BAD) begin
      pos_d = '0;
      len_d = '0;
      xor_d = '0;
    end
  end

  assign result_o.outcome    = outcome;
  assign result_o.byte_index = pos_q;
  assign result_o.byte_value = rx_byte_i;

  // Frame state advances once per accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      len_q <= '0;
      xor_q <= '0;
    end else if (take_i) begin
      pos_q <= pos_d;
      len_q <= len_d;
      xor_q <= xor_d;
    end
  end

endmodule

// ----- rtl/frp_out_reg.sv -----
module frp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  frp_pkg::result_t  result_i,
  input  logic              out_ready_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  output frp_pkg::result_t  result_o
);

  logic             valid_q;
  frp_pkg::result_t data_q;

  // A new result may enter when the register is empty or being drained.
  assign can_load_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= load_i;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

// ----- rtl/framed_packet_receiver_xor_check_top.sv -----
// Framed packet receiver with XOR check. Each received byte is one input
// transaction and yields exactly one result transaction: the outcome
// (ignored, accepted, dropped, good, check failed), the byte's position in
// the frame and the byte itself. Frames are AA BB, source, destination,
// length, payload, check; the check must equal the XOR of source through
// the last payload byte. A frame whose length plus six exceeds
// FRAME_BUFFER_BYTES, or whose destination is not the local address, FF or
// EE, is dropped. One byte is taken every cycle: the frame state updates in
// the accept cycle and the result appears from the output register in the
// next cycle; the input stalls only while that register holds a result
// that is not being taken. Write local_address only while no transaction
// is in flight.
module framed_packet_receiver_xor_check_top #(
  parameter int unsigned FRAME_BUFFER_BYTES = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [frp_pkg::ByteW-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [frp_pkg::ByteW-1:0]  rx_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [2:0]                 outcome_o,
  output logic [frp_pkg::PosW-1:0]   byte_index_o,
  output logic [frp_pkg::ByteW-1:0]  byte_value_o
);

  logic [frp_pkg::ByteW-1:0] local_address_q;
  logic                      take;
  frp_pkg::result_t          step_result;
  frp_pkg::result_t          out_result;

  // Local address register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_address_q <= '0;
    end else if (cfg_we_i) begin
      local_address_q <= cfg_wdata_i;
    end
  end

  assign take = in_valid_i && in_ready_o;

  frp_deframe #(
    .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
  ) u_deframe (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .take_i          (take),
    .rx_byte_i       (rx_byte_i),
    .local_address_i (local_address_q),
    .result_o        (step_result)
  );

  frp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .result_i    (step_result),
    .out_ready_i (out_ready_i),
    .can_load_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .result_o    (out_result)
  );

  assign outcome_o    = out_result.outcome;
  assign byte_index_o = out_result.byte_index;
  assign byte_value_o = out_result.byte_value;

  // Every accepted byte produces a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_o)
    else $error("accepted byte produced no result");

  // A result transaction echoes the byte that was accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> byte_value_o == $past(rx_byte_i))
    else $error("echoed byte differs from accepted byte");

  // Ignored bytes only occur while hunting, at position zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outcome_o == frp_pkg::OUT_IGNORED) |-> byte_index_o == '0)
    else $error("ignored byte reported outside hunting");

  // A check result can only come after the frame header.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (outcome_o == frp_pkg::OUT_GOOD || outcome_o == frp_pkg::OUT_BAD))
      |-> byte_index_o >= frp_pkg::PosW'(5))
    else $error("check outcome at a header position");

endmodule

// ----- sim/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FrameBufferBytes = 32;
  localparam int unsigned HalfPeriod       = 5;
  localparam int unsigned CycleLimit       = 400000;
  localparam int unsigned BytesPerPhase    = 270;
  localparam int unsigned PhaseCount       = 6;
  localparam int unsigned LongestPayload   = FrameBufferBytes - frp_pkg::FrameOverhead;
  localparam int unsigned ReceiverHoldOff  = 150;

  // One row of the directed sequence. Rows with given set carry their own
  // expected outcome and index; the rest are checked against the predictor.
  typedef struct packed {
    logic [frp_pkg::ByteW-1:0] rx;
    logic                      given;
    frp_pkg::outcome_e         outcome;
    logic [frp_pkg::PosW-1:0]  index;
  } stim_row_t;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [frp_pkg::ByteW-1:0] cfg_wdata_i = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic [frp_pkg::ByteW-1:0] rx_byte_i   = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [2:0]                outcome_o;
  logic [frp_pkg::PosW-1:0]  byte_index_o;
  logic [frp_pkg::ByteW-1:0] byte_value_o;

  // Predictor state: mirrors the receiver's frame tracking.
  logic [frp_pkg::PosW-1:0]  frame_pos  = '0;
  logic [frp_pkg::ByteW-1:0] frame_len  = '0;
  logic [frp_pkg::ByteW-1:0] frame_xor  = '0;
  logic [frp_pkg::ByteW-1:0] local_addr = '0;

  frp_pkg::result_t frame_results_due[$];
  int      mismatches        = 0;
  int      frame_bytes_taken = 0;
  int      cycle_count       = 0;
  int      gap_pct           = 0;
  int      stall_pct         = 0;
  bit      hold_req          = 1'b0;

  stim_row_t directed_rows [26] = '{
    '{8'h00, 1'b1, frp_pkg::OUT_IGNORED,  frp_pkg::PosSync1},
    '{8'hFF, 1'b1, frp_pkg::OUT_IGNORED,  frp_pkg::PosSync1},
    '{8'hAA, 1'b0, frp_pkg::OUT_ACCEPTED, frp_pkg::PosSync1},
    '{8'hAA, 1'b1, frp_pkg::OUT_DROPPED,  frp_pkg::PosSync2},
    '{8'hAA, 1'b0, frp_pkg::OUT_ACCEPTED, frp_pkg::PosSync1},
    '{8'hBB, 1'b0, frp_pkg::OUT_ACCEPTED, frp_pkg::PosSync1},
    '{8'h12, 1'b0, frp_pkg::OUT_ACCEPTED, frp_pkg::PosSync1},
    '{8'h34, 1'b1, frp_pkg::OUT_DROPPED,  frp_pkg::PosDest},
    '{8'hAA, 1'b0, frp_pkg::OUT_ACCEPTED, frp_pkg::PosSync1},
    '{8'hBB, 1'b0, frp_pkg::OUT_ACCEPTED, frp_pkg::PosSync1},
    '{8'h00, 1'b0, frp_pkg::OUT_ACCEPTED, frp_pkg::PosSync1},
    '{8'hFF, 1'b0, frp_pkg::OUT_ACCEPTED, frp_pkg::PosSync1},
    '{8'h1B, 1'b1, frp_pkg::OUT_DROPPED,  frp_pkg::PosLength},
    '{8'hAA, 1'b0, frp_pkg::OUT_ACCEPTED, frp_pkg::PosSync1},
    '{8'hBB, 1'b0, frp_pkg::OUT_ACCEPTED, frp_pkg::PosSync1},
    '{8'h01, 1'b0, frp_pkg::OUT_ACCEPTED, frp_pkg::PosSync1},
    '{8'hEE, 1'b0, frp_pkg::OUT_ACCEPTED, frp_pkg::PosSync1},
    '{8'h00, 1'b1, frp_pkg::OUT_ACCEPTED, frp_pkg::PosLength},
    '{8'hEF, 1'b1, frp_pkg::OUT_GOOD,     9'd5},
    '{8'hAA, 1'b0, frp_pkg::OUT_ACCEPTED, frp_pkg::PosSync1},
    '{8'hBB, 1'b0, frp_pkg::OUT_ACCEPTED, frp_pkg::PosSync1},
    '{8'h00, 1'b0, frp_pkg::OUT_ACCEPTED, frp_pkg::PosSync1},
    '{8'h00, 1'b0, frp_pkg::OUT_ACCEPTED, frp_pkg::PosSync1},
    '{8'h01, 1'b0, frp_pkg::OUT_ACCEPTED, frp_pkg::PosSync1},
    '{8'h55, 1'b0, frp_pkg::OUT_ACCEPTED, frp_pkg::PosSync1},
    '{8'h00, 1'b1, frp_pkg::OUT_BAD,      9'd6}
  };

  framed_packet_receiver_xor_check_top #(
    .FRAME_BUFFER_BYTES(FrameBufferBytes)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .outcome_o   (outcome_o),
    .byte_index_o(byte_index_o),
    .byte_value_o(byte_value_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Give up if the run stalls far beyond the slowest legal pace.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic start_hunting();
    frame_pos = frp_pkg::PosSync1;
    frame_len = '0;
    frame_xor = '0;
  endtask

  // Advance the frame tracker by one byte and work out its result.
  task automatic track_frame(input logic [frp_pkg::ByteW-1:0] b,
                             output frp_pkg::result_t res);
    res.outcome    = frp_pkg::OUT_ACCEPTED;
    res.byte_index = frame_pos;
    res.byte_value = b;
    if (frame_pos == frp_pkg::PosSync1) begin
      if (b == frp_pkg::SyncFirst) begin
        frame_xor = '0;
        frame_pos = frp_pkg::PosSync2;
      end else begin
        res.outcome = frp_pkg::OUT_IGNORED;
      end
    end else if (frame_pos == frp_pkg::PosSync2) begin
      if (b == frp_pkg::SyncSecond) begin
        frame_pos = frp_pkg::PosSource;
      end else begin
        res.outcome = frp_pkg::OUT_DROPPED;
        start_hunting();
      end
    end else if (frame_pos == frp_pkg::PosSource) begin
      frame_xor = b;
      frame_pos = frp_pkg::PosDest;
    end else if (frame_pos == frp_pkg::PosDest) begin
      if (b != local_addr && b != frp_pkg::AddrBroadcastA &&
          b != frp_pkg::AddrBroadcastB) begin
        res.outcome = frp_pkg::OUT_DROPPED;
        start_hunting();
      end else begin
        frame_xor ^= b;
        frame_pos = frp_pkg::PosLength;
      end
    end else if (frame_pos == frp_pkg::PosLength) begin
      if (int'(b) + frp_pkg::FrameOverhead > FrameBufferBytes) begin
        res.outcome = frp_pkg::OUT_DROPPED;
        start_hunting();
      end else begin
        frame_len = b;
        frame_xor ^= b;
        frame_pos = frame_pos + frp_pkg::PosW'(1);
      end
    end else if (int'(frame_pos) <= int'(frame_len) + 4) begin
      frame_xor ^= b;
      frame_pos = frame_pos + frp_pkg::PosW'(1);
    end else if (int'(frame_pos) == int'(frame_len) + 5) begin
      res.outcome = (frame_xor == b) ? frp_pkg::OUT_GOOD : frp_pkg::OUT_BAD;
      start_hunting();
    end else begin
      // A position past the check byte should never happen; resync.
      res.outcome = frp_pkg::OUT_DROPPED;
      start_hunting();
    end
  endtask

  // Offer one byte after a random gap and record its expected result once
  // the transaction is accepted.
  task automatic send_byte(input logic [frp_pkg::ByteW-1:0] b, input bit given,
                           input frp_pkg::result_t given_res);
    int               gap;
    frp_pkg::result_t pred;
    gap = 0;
    while (gap < 60 && $urandom_range(0, 99) < gap_pct) gap++;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    track_frame(b, pred);
    frame_results_due.push_back(given ? given_res : pred);
    frame_bytes_taken++;
  endtask

  // Stop offering and wait for every outstanding result, plus the
  // pipeline latency, so the receiver is idle afterwards.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_local_address(input logic [frp_pkg::ByteW-1:0] addr);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= addr;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    local_addr = addr;
  endtask

  // Line noise, then a frame with random content. Only some frames are well
  // formed; others carry a foreign address, an oversize length, a bad check,
  // a broken second sync byte or a premature end.
  task automatic send_random_frame();
    logic [frp_pkg::ByteW-1:0] fb[$];
    logic [frp_pkg::ByteW-1:0] len;
    logic [frp_pkg::ByteW-1:0] dest;
    logic [frp_pkg::ByteW-1:0] chk;
    logic [frp_pkg::ByteW-1:0] b;
    int                        n_send;
    repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0, '0);

    case ($urandom_range(0, 9))
      0, 1, 2: dest = local_addr;
      3, 4:    dest = frp_pkg::AddrBroadcastA;
      5, 6:    dest = frp_pkg::AddrBroadcastB;
      default: dest = 8'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: len = 8'($urandom_range(0, 6));
      5:             len = 8'($urandom_range(7, LongestPayload));
      6:             len = 8'(LongestPayload);
      7:             len = 8'(LongestPayload + 1);
      default:       len = 8'($urandom_range(LongestPayload + 1, 255));
    endcase

    fb.push_back(frp_pkg::SyncFirst);
    fb.push_back(frp_pkg::SyncSecond);
    b = 8'($urandom);
    fb.push_back(b);
    chk = b ^ dest ^ len;
    fb.push_back(dest);
    fb.push_back(len);
    if (int'(len) <= LongestPayload) begin
      repeat (len) begin
        b = 8'($urandom);
        fb.push_back(b);
        chk ^= b;
      end
      if ($urandom_range(0, 4) == 0) chk ^= 8'($urandom_range(1, 255));
      fb.push_back(chk);
      n_send = fb.size();
    end else begin
      // The length byte drops it; a few trailing bytes land in the hunt.
      repeat (3) fb.push_back(8'($urandom));
      n_send = fb.size();
    end

    case ($urandom_range(0, 19))
      0:       fb[1] = 8'($urandom);
      1:       n_send = $urandom_range(1, fb.size() - 1);
      default: ;
    endcase
    for (int i = 0; i < n_send; i++) send_byte(fb[i], 1'b0, '0);
  endtask

  // Receiver side: random stalls, and one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = ReceiverHoldOff;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    frp_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frame_results_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result outcome=%0d index=%0d value=%02h",
                                outcome_o, byte_index_o, byte_value_o));
      end else begin
        want = frame_results_due.pop_front();
        if (outcome_o != want.outcome) begin
          flag_mismatch($sformatf("outcome %0d, expected %0d (byte %02h)",
                                  outcome_o, want.outcome, want.byte_value));
        end
        if (byte_index_o != want.byte_index) begin
          flag_mismatch($sformatf("byte_index %0d, expected %0d",
                                  byte_index_o, want.byte_index));
        end
        if (byte_value_o != want.byte_value) begin
          flag_mismatch($sformatf("byte_value %02h, expected %02h",
                                  byte_value_o, want.byte_value));
        end
      end
    end
  end

  // Main sequence: reset, directed rows, then random phases that each set
  // a local address and an idling pattern, not always different ones.
  initial begin
    frp_pkg::result_t given_res;
    stim_row_t        row;
    logic [7:0]       addr;
    int               phase_start;
    bit               hold_done;
    bit               pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    start_hunting();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the reset address of zero.
    foreach (directed_rows[i]) begin
      row                  = directed_rows[i];
      given_res.outcome    = row.outcome;
      given_res.byte_index = row.index;
      given_res.byte_value = row.rx;
      send_byte(row.rx, row.given, given_res);
    end
    wait_drained();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: begin addr = 8'hFF; gap_pct = 0;  stall_pct = 0;  end
        1: begin addr = 8'h00; gap_pct = 80; stall_pct = 0;  end
        2: begin addr = 8'hEE; gap_pct = 0;  stall_pct = 80; end
        3: begin addr = 8'($urandom_range(1, 254)); gap_pct = 38; stall_pct = 38; end
        4: begin addr = 8'($urandom); gap_pct = 0; stall_pct = 0; end
        default: begin addr = 8'h80; gap_pct = 38; stall_pct = 38; end
      endcase
      write_local_address(addr);
      phase_start = frame_bytes_taken;
      while (frame_bytes_taken < phase_start + BytesPerPhase) begin
        send_random_frame();
        // After 100 bytes of the phase, the receiver holds off long enough to fill
        // the block while bytes keep coming.
        if (ph == 2 && !hold_done && frame_bytes_taken >= phase_start + 100) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        // Here the sender pauses until every result is back.
        if (ph == 3 && !pause_done && frame_bytes_taken >= phase_start + 100) begin
          wait_drained();
          pause_done = 1'b1;
        end
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
